/* design/seconds_to_calendar_date_assert.svh */
// Assertion macros shared by the seconds-to-date design
`ifndef SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define STCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle
`define STCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* design/stcd_pkg.sv */
// Shared constants, types and helper functions for the seconds-to-date converter
package stcd_pkg;

    localparam int EPOCH_YEAR      = 2000;
    localparam int SECS_PER_DAY    = 86400;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_MINUTE = 60;

    localparam int SEC_W   = 32;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int DAYS_W  = 16;
    localparam int SOD_W   = 17;
    localparam int REM_W   = 12;
    localparam int YLEN_W  = 9;
    localparam int CNT_W   = 1;

    // Each division takes a quotient step and then a remainder step
    localparam logic [CNT_W-1:0] DIV_LAST_STEP = 1'b1;

    // Divide by a constant: strip its power of two by a shift, then take the quotient by the
    // odd part as (x * ceil(2^shift / odd)) >> shift, exact over the operand's full range
    localparam int DAY_SHIFT        = 7;
    localparam int DAY_ODD          = SECS_PER_DAY >> DAY_SHIFT;
    localparam int DAY_ODD_W        = 10;
    localparam int DAY_RECIP        = 50903317;
    localparam int DAY_RECIP_W      = 26;
    localparam int DAY_RECIP_SHIFT  = 35;

    localparam int HOUR_SHIFT       = 4;
    localparam int HOUR_ODD         = SECS_PER_HOUR >> HOUR_SHIFT;
    localparam int HOUR_ODD_W       = 8;
    localparam int HOUR_RECIP       = 9321;
    localparam int HOUR_RECIP_W     = 14;
    localparam int HOUR_RECIP_SHIFT = 21;

    localparam int MIN_SHIFT        = 2;
    localparam int MIN_ODD          = SECS_PER_MINUTE >> MIN_SHIFT;
    localparam int MIN_ODD_W        = 4;
    localparam int MIN_RECIP        = 1093;
    localparam int MIN_RECIP_W      = 11;
    localparam int MIN_RECIP_SHIFT  = 14;

    // Month indexes, January is zero
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd5;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd8;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd10;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd11;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } div_op_t;

    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    div_last;
        div_op_t div_op;
        logic    year_step;
        logic    month_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic year_fits;
        logic month_fits;
    } dp_status_t;

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] mon,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (mon) inside
            MON_FEB:                            len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default:                            len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* design/seconds_to_calendar_date.sv */
// Sequence: three reciprocal divisions (days, hours, minutes), each a quotient step then a remainder
//   step, then a year walk over Y = 0..136 years and a month walk over M = 0..11 months, each
//   subtracting one year or month length per step and taking one exit step; done rises at the end.
// Throughput: one request at a time; busy drops with done, so the next may be taken then.
// Results are valid for the single cycle that done is high; the receiver cannot stall.
// Reset (rst_n low, asynchronous) returns the controller to idle and drops a request in flight.
module seconds_to_calendar_date #(
    parameter int EPOCH_YEAR = stcd_pkg::EPOCH_YEAR
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [stcd_pkg::SEC_W-1:0]    epoch_seconds,
    output logic                          done,
    output logic [stcd_pkg::YEAR_W-1:0]   year_number,
    output logic [stcd_pkg::MONTH_W-1:0]  month_number,
    output logic [stcd_pkg::DAY_W-1:0]    day_of_month,
    output logic [stcd_pkg::HOUR_W-1:0]   hour_of_day,
    output logic [stcd_pkg::MIN_W-1:0]    minute_of_hour,
    output logic [stcd_pkg::MIN_W-1:0]    second_of_minute
);
    import stcd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequence the conversion
    stcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Hold the division and calendar walk registers
    stcd_dpath #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_dpath (
        .clk              (clk),
        .epoch_seconds    (epoch_seconds),
        .cmd              (cmd),
        .status           (status),
        .year_number      (year_number),
        .month_number     (month_number),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute)
    );

endmodule

/* design/stcd_dpath.sv */
// Datapath: reciprocal constant division, year walk and month walk registers
module stcd_dpath #(
    parameter int EPOCH_YEAR = stcd_pkg::EPOCH_YEAR
) (
    input  logic                                  clk,
    input  logic [stcd_pkg::SEC_W-1:0]            epoch_seconds,
    input  stcd_pkg::ctrl_cmd_t                   cmd,
    output stcd_pkg::dp_status_t                  status,
    output logic [stcd_pkg::YEAR_W-1:0]           year_number,
    output logic [stcd_pkg::MONTH_W-1:0]          month_number,
    output logic [stcd_pkg::DAY_W-1:0]            day_of_month,
    output logic [stcd_pkg::HOUR_W-1:0]           hour_of_day,
    output logic [stcd_pkg::MIN_W-1:0]            minute_of_hour,
    output logic [stcd_pkg::MIN_W-1:0]            second_of_minute
);
    import stcd_pkg::*;

    localparam int DAY_A_W     = SEC_W - DAY_SHIFT;
    localparam int DAY_PROD_W  = DAY_A_W + DAY_RECIP_W;
    localparam int HOUR_B_W    = SOD_W - HOUR_SHIFT;
    localparam int HOUR_PROD_W = HOUR_B_W + HOUR_RECIP_W;
    localparam int MIN_C_W     = REM_W - MIN_SHIFT;
    localparam int MIN_PROD_W  = MIN_C_W + MIN_RECIP_W;

    localparam logic [1:0] Y4_INIT   = 2'(EPOCH_YEAR % 4);
    localparam logic [6:0] Y100_INIT = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0] Y400_INIT = 9'(EPOCH_YEAR % 400);

    logic [SEC_W-1:0]   secs_reg;
    logic [SOD_W-1:0]   sod_reg;
    logic [DAYS_W-1:0]  days_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [1:0]         y4_reg;
    logic [6:0]         y100_reg;
    logic [8:0]         y400_reg;
    logic [MONTH_W-1:0] mon_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [MIN_W-1:0]   min_reg;
    logic [MIN_W-1:0]   sec_reg;

    logic [DAY_A_W-1:0]     day_a;
    logic [DAY_PROD_W-1:0]  day_prod;
    logic [DAYS_W-1:0]      day_quo;
    logic [DAY_A_W-1:0]     day_back;
    logic [DAY_A_W-1:0]     day_left;
    logic [SOD_W-1:0]       sod_next;
    logic [HOUR_B_W-1:0]    hour_b;
    logic [HOUR_PROD_W-1:0] hour_prod;
    logic [HOUR_W-1:0]      hour_quo;
    logic [HOUR_B_W-1:0]    hour_back;
    logic [HOUR_B_W-1:0]    hour_left;
    logic [REM_W-1:0]       hour_rem;
    logic [MIN_C_W-1:0]     min_c;
    logic [MIN_PROD_W-1:0]  min_prod;
    logic [MIN_W-1:0]       min_quo;
    logic [MIN_C_W-1:0]     min_back;
    logic [MIN_C_W-1:0]     min_left;
    logic [MIN_W-1:0]       sec_next;
    logic                   leap;
    logic [YLEN_W-1:0]      ylen;
    logic [DAY_W-1:0]       mlen;

    // Split seconds into whole days and seconds of the day
    always_comb
    begin
        day_a    = secs_reg[SEC_W-1:DAY_SHIFT];
        day_prod = DAY_PROD_W'(day_a) * DAY_PROD_W'(DAY_RECIP);
        day_quo  = day_prod[DAY_RECIP_SHIFT +: DAYS_W];
        day_back = DAY_A_W'(days_reg) * DAY_A_W'(DAY_ODD);
        day_left = day_a - day_back;
        sod_next = {day_left[DAY_ODD_W-1:0], secs_reg[DAY_SHIFT-1:0]};
    end

    // Split seconds of the day into hours and seconds of the hour
    always_comb
    begin
        hour_b    = sod_reg[SOD_W-1:HOUR_SHIFT];
        hour_prod = HOUR_PROD_W'(hour_b) * HOUR_PROD_W'(HOUR_RECIP);
        hour_quo  = hour_prod[HOUR_RECIP_SHIFT +: HOUR_W];
        hour_back = HOUR_B_W'(hour_reg) * HOUR_B_W'(HOUR_ODD);
        hour_left = hour_b - hour_back;
        hour_rem  = {hour_left[HOUR_ODD_W-1:0], sod_reg[HOUR_SHIFT-1:0]};
    end

    // Split seconds of the hour into minutes and seconds
    always_comb
    begin
        min_c    = sod_reg[REM_W-1:MIN_SHIFT];
        min_prod = MIN_PROD_W'(min_c) * MIN_PROD_W'(MIN_RECIP);
        min_quo  = min_prod[MIN_RECIP_SHIFT +: MIN_W];
        min_back = MIN_C_W'(min_reg) * MIN_C_W'(MIN_ODD);
        min_left = min_c - min_back;
        sec_next = {min_left[MIN_ODD_W-1:0], sod_reg[MIN_SHIFT-1:0]};
    end

    // Leap year under the 4/100/400 rule and the current year and month lengths
    always_comb
    begin
        leap = (y4_reg == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 9'd0));
        ylen = leap ? 9'd366 : 9'd365;
        mlen = month_length(mon_reg, leap);
    end

    assign status.year_fits  = ({{(DAYS_W-YLEN_W){1'b0}}, ylen} > days_reg);
    assign status.month_fits = ({{(DAYS_W-DAY_W){1'b0}}, mlen} > days_reg) ||
                               (mon_reg == MON_DEC);

    // Load, divide, then walk years and months
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            secs_reg <= epoch_seconds;
            year_reg <= YEAR_W'(EPOCH_YEAR);
            y4_reg   <= Y4_INIT;
            y100_reg <= Y100_INIT;
            y400_reg <= Y400_INIT;
            mon_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            case (cmd.div_op)
                DIV_DAY:
                begin
                    if (cmd.div_last)
                        sod_reg  <= sod_next;
                    else
                        days_reg <= day_quo;
                end
                DIV_HOUR:
                begin
                    if (cmd.div_last)
                        sod_reg  <= SOD_W'(hour_rem);
                    else
                        hour_reg <= hour_quo;
                end
                default:
                begin
                    if (cmd.div_last)
                        sec_reg <= sec_next;
                    else
                        min_reg <= min_quo;
                end
            endcase
        end
        else if (cmd.year_step)
        begin
            days_reg <= days_reg - {{(DAYS_W-YLEN_W){1'b0}}, ylen};
            year_reg <= year_reg + 1'b1;
            y4_reg   <= y4_reg + 1'b1;
            y100_reg <= (y100_reg == 7'd99)  ? 7'd0 : y100_reg + 1'b1;
            y400_reg <= (y400_reg == 9'd399) ? 9'd0 : y400_reg + 1'b1;
        end
        else if (cmd.month_step)
        begin
            days_reg <= days_reg - {{(DAYS_W-DAY_W){1'b0}}, mlen};
            mon_reg  <= mon_reg + 1'b1;
        end
    end

    assign year_number      = year_reg;
    assign month_number     = mon_reg + 4'd1;
    assign day_of_month     = days_reg[DAY_W-1:0] + 5'd1;
    assign hour_of_day      = hour_reg;
    assign minute_of_hour   = min_reg;
    assign second_of_minute = sec_reg;

endmodule

/* design/stcd_ctrl.sv */
// Controller: sequences the divisions, the year walk and the month walk
`include "seconds_to_calendar_date_assert.svh"

module stcd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  stcd_pkg::dp_status_t status,
    output stcd_pkg::ctrl_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);
    import stcd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_YEAR,
        ST_MONTH
    } state_t;

    state_t           state_reg;
    div_op_t          op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // Decode commands for the datapath
    always_comb
    begin
        cmd.load       = start && !busy_reg;
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.div_last   = (cnt_reg == '0);
        cmd.div_op     = op_reg;
        cmd.year_step  = (state_reg == ST_YEAR)  && !status.year_fits;
        cmd.month_step = (state_reg == ST_MONTH) && !status.month_fits;
    end

    // Advance state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= DIV_DAY;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_DIV;
                        op_reg    <= DIV_DAY;
                        cnt_reg   <= DIV_LAST_STEP;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        unique case (op_reg)
                            DIV_DAY:
                            begin
                                op_reg  <= DIV_HOUR;
                                cnt_reg <= DIV_LAST_STEP;
                            end
                            DIV_HOUR:
                            begin
                                op_reg  <= DIV_MIN;
                                cnt_reg <= DIV_LAST_STEP;
                            end
                            default:
                            begin
                                state_reg <= ST_YEAR;
                            end
                        endcase
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_YEAR:
                begin
                    if (status.year_fits)
                    begin
                        state_reg <= ST_MONTH;
                    end
                end
                ST_MONTH:
                begin
                    if (status.month_fits)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `STCD_ASSERT_SAME(a_busy_tracks_state, clk, rst_n,
                      1'b1, busy_reg == (state_reg != ST_IDLE))
    `STCD_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n,
                      start && !busy_reg, busy_reg && state_reg == ST_DIV)
    `STCD_ASSERT_NEXT(a_month_done_strobe, clk, rst_n,
                      state_reg == ST_MONTH && status.month_fits, done_reg && !busy_reg)
    `STCD_ASSERT_SAME(a_done_only_when_idle, clk, rst_n,
                      done_reg, state_reg == ST_IDLE)

endmodule

/* tb/seconds_to_calendar_date_checker.sv */
// Checker that predicts each calendar date from the requested seconds and compares the results
`timescale 1ns / 1ps

module seconds_to_calendar_date_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [stcd_pkg::SEC_W-1:0]    epoch_seconds,
    input  logic                          done,
    input  logic [stcd_pkg::YEAR_W-1:0]   year_number,
    input  logic [stcd_pkg::MONTH_W-1:0]  month_number,
    input  logic [stcd_pkg::DAY_W-1:0]    day_of_month,
    input  logic [stcd_pkg::HOUR_W-1:0]   hour_of_day,
    input  logic [stcd_pkg::MIN_W-1:0]    minute_of_hour,
    input  logic [stcd_pkg::MIN_W-1:0]    second_of_minute,
    output int                            mismatches,
    output int                            outstanding,
    output int                            compared
);
    import stcd_pkg::*;

    localparam int unsigned DAY_SECONDS    = 86400;
    localparam int unsigned HOUR_SECONDS   = 3600;
    localparam int unsigned MINUTE_SECONDS = 60;
    localparam int          REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [SEC_W-1:0]   secs;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [MIN_W-1:0]   second;
    } civil_time_t;

    civil_time_t pending_dates[$];
    int          bad_count  = 0;
    int          open_count = 0;
    int          good_count = 0;

    assign mismatches  = bad_count;
    assign outstanding = open_count;
    assign compared    = good_count;

    function automatic logic leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    // Month is 1-based here
    function automatic int unsigned month_days(input int unsigned mon, input logic leap);
        case (mon)
            2:            return leap ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    // Walk whole years, then whole months, from the start of the epoch year
    function automatic civil_time_t civil_from_seconds(input logic [SEC_W-1:0] secs);
        civil_time_t  c;
        int unsigned  days;
        int unsigned  sod;
        int unsigned  yr;
        int unsigned  mon;
        int unsigned  span;
        days = secs / DAY_SECONDS;
        sod  = secs % DAY_SECONDS;
        yr   = EPOCH_YEAR;
        span = leap_year(yr) ? 366 : 365;
        while (days >= span)
        begin
            days -= span;
            yr++;
            span = leap_year(yr) ? 366 : 365;
        end
        mon = 1;
        while (mon < 12 && days >= month_days(mon, leap_year(yr)))
        begin
            days -= month_days(mon, leap_year(yr));
            mon++;
        end
        c.secs   = secs;
        c.year   = YEAR_W'(yr);
        c.month  = MONTH_W'(mon);
        c.day    = DAY_W'(days + 1);
        c.hour   = HOUR_W'(sod / HOUR_SECONDS);
        c.minute = MIN_W'((sod % HOUR_SECONDS) / MINUTE_SECONDS);
        c.second = MIN_W'(sod % MINUTE_SECONDS);
        return c;
    endfunction

    // Retire the finished date first, then record a newly accepted request
    always @(posedge clk)
    begin : watch_ports
        civil_time_t want;
        civil_time_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got.secs   = '0;
                got.year   = year_number;
                got.month  = month_number;
                got.day    = day_of_month;
                got.hour   = hour_of_day;
                got.minute = minute_of_hour;
                got.second = second_of_minute;
                if (pending_dates.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= REPORT_LIMIT)
                        $display("%0t: result with no request waiting: %0d-%0d-%0d %0d:%0d:%0d",
                                 $realtime, got.year, got.month, got.day,
                                 got.hour, got.minute, got.second);
                end
                else
                begin
                    want     = pending_dates.pop_front();
                    got.secs = want.secs;
                    good_count++;
                    if (got != want)
                    begin
                        bad_count++;
                        if (bad_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch for %0d s: expected %0d-%0d-%0d %0d:%0d:%0d",
                                     $realtime, want.secs,
                                     want.year, want.month, want.day,
                                     want.hour, want.minute, want.second);
                            $display("%0t:   actual %0d-%0d-%0d %0d:%0d:%0d",
                                     $realtime,
                                     got.year, got.month, got.day,
                                     got.hour, got.minute, got.second);
                        end
                    end
                end
            end
            if (start && !busy)
                pending_dates.push_back(civil_from_seconds(epoch_seconds));
            open_count = pending_dates.size();
        end
    end

endmodule

/* tb/tb_seconds_to_calendar_date.sv */
// Testbench top that drives seconds-to-date conversion requests and reports the verdict
`timescale 1ns / 1ps

module tb_seconds_to_calendar_date;
    import stcd_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 5;
    localparam int RANDOM_REQUESTS = 1450;
    localparam int CORNER_COUNT    = 25;
    localparam int MAX_GAP         = 7;
    localparam int DRAIN_CYCLES    = 220;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int LAST_WHOLE_DAY  = 49710;

    typedef enum int {
        PICK_ANY,
        PICK_DAY_EDGE,
        PICK_NEAR_EPOCH,
        PICK_NEAR_WRAP
    } pick_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [SEC_W-1:0]     epoch_seconds = '0;
    logic                 done;
    logic [YEAR_W-1:0]    year_number;
    logic [MONTH_W-1:0]   month_number;
    logic [DAY_W-1:0]     day_of_month;
    logic [HOUR_W-1:0]    hour_of_day;
    logic [MIN_W-1:0]     minute_of_hour;
    logic [MIN_W-1:0]     second_of_minute;

    int mismatches;
    int outstanding;
    int compared;
    int requests_sent = 0;
    int cycle_count   = 0;

    // Seconds, minutes, hours, leap days, year ends, the 2100 century rule and the top value
    logic [SEC_W-1:0] corner_seconds [CORNER_COUNT] = '{
        32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'(59 * 86400 - 1), 32'(59 * 86400), 32'(60 * 86400 - 1), 32'(60 * 86400),
        32'(366 * 86400 - 1), 32'(366 * 86400),
        32'(425 * 86400 - 1), 32'(425 * 86400), 32'(1520 * 86400),
        32'(64'd36525 * 64'd86400 - 64'd1), 32'(64'd36525 * 64'd86400),
        32'(64'd36584 * 64'd86400 - 64'd1), 32'(64'd49673 * 64'd86400),
        32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF
    };

    seconds_to_calendar_date dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .year_number      (year_number),
        .month_number     (month_number),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute)
    );

    seconds_to_calendar_date_checker chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .year_number      (year_number),
        .month_number     (month_number),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .compared         (compared)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d dates still owed", cycle_count, outstanding);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold the request from a falling edge until a rising edge sees busy low
    task automatic send_request(input logic [SEC_W-1:0] secs, input int max_gap);
        int   gap;
        logic stalled;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            start         <= 1'b0;
            epoch_seconds <= $urandom();
            repeat (gap) @(negedge clk);
        end
        start         <= 1'b1;
        epoch_seconds <= secs;
        do begin
            stalled = busy;
            @(negedge clk);
        end while (stalled);
        requests_sent++;
    endtask

    initial
    begin
        logic [SEC_W-1:0] secs;
        logic [63:0]      stamp;
        int               offset;
        int               gap_limit;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Drive corner points first
        for (int i = 0; i < CORNER_COUNT; i++)
            send_request(corner_seconds[i], MAX_GAP);

        // Mix random stamps; every hundred requests start with a back-to-back burst
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            gap_limit = (i % 100 < 20) ? 0 : MAX_GAP;
            case (pick_t'($urandom_range(PICK_ANY, PICK_NEAR_WRAP)))
                PICK_ANY:
                    secs = $urandom();
                PICK_DAY_EDGE:
                begin
                    case ($urandom_range(0, 2))
                        0:       offset = 0;
                        1:       offset = 86399;
                        default: offset = $urandom_range(0, 86399);
                    endcase
                    stamp = 64'($urandom_range(0, LAST_WHOLE_DAY)) * 64'd86400 + 64'(offset);
                    if (stamp > 64'hFFFF_FFFF)
                        stamp = 64'hFFFF_FFFF;
                    secs = stamp[SEC_W-1:0];
                end
                PICK_NEAR_EPOCH:
                    secs = SEC_W'($urandom_range(0, 1 << 20));
                default:
                    secs = 32'hFFFF_FFFF - SEC_W'($urandom_range(0, 1 << 24));
            endcase
            send_request(secs, gap_limit);
        end
        start <= 1'b0;

        // Drain the remaining dates, then watch for stray results
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d conversion requests: %0d corner stamps and %0d random stamps",
                 requests_sent, CORNER_COUNT, requests_sent - CORNER_COUNT);
        $display("checked %0d dates field by field, %0d mismatches", compared, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
